// ===== rtl/core/safer_sk_block_cipher_core_macros.svh =====
// Assertion macros shared by the SAFER SK core checkers.
// No dependencies; included by the checker file.
`ifndef SAFER_SK_BLOCK_CIPHER_CORE_MACROS_SVH
`define SAFER_SK_BLOCK_CIPHER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("SSK assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("SSK assertion failed");

`endif

// ===== rtl/core/ssk_pkg.sv =====
// Shared types, constants, S-box tables and linear layers of the SAFER SK core.
// No dependencies; used by every module of the core.
`default_nettype none
package ssk_pkg;

  localparam int MAX_ROUNDS = 13;
  localparam int BLK_W      = 64;
  localparam int RND_W      = 4;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_KEY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_CNT  = 2'd3;

  localparam logic [RND_W-1:0] ROUND_CNT_RST = 4'd8;

  typedef logic [7:0] rom_t [256];

  // Work performed by one byte cell in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_LOAD    = 3'd1,
    CELL_ENC_RND = 3'd2,
    CELL_DEC_RND = 3'd3,
    CELL_ENC_FIN = 3'd4,
    CELL_DEC_FIN = 3'd5
  } cell_mode_e;

  // Exponent table 45^x mod 257, with 256 stored as 0.
  function automatic rom_t gen_exp();
    rom_t        t;
    logic [15:0] v;
    v = 16'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = v[7:0];
      v = (v * 16'd45) % 16'd257;
    end
    return t;
  endfunction

  // Logarithm table, the inverse of the exponent table.
  function automatic rom_t gen_log();
    rom_t e;
    rom_t t;
    e = gen_exp();
    for (int i = 0; i < 256; i++) begin
      t[e[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam rom_t EXP_TAB = gen_exp();
  localparam rom_t LOG_TAB = gen_log();

  function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
    return 8'((x << n) | (x >> (8 - n)));
  endfunction

  // Three PHT layers and the byte shuffle of an encryption round.
  function automatic logic [BLK_W-1:0] pht_round(input logic [BLK_W-1:0] x);
    logic [7:0] c [8];
    logic [7:0] t;
    for (int j = 0; j < 8; j++) c[j] = x[BLK_W-1-8*j -: 8];
    for (int p = 0; p < 8; p += 2) begin
      c[p+1] = c[p+1] + c[p];
      c[p]   = c[p] + c[p+1];
    end
    for (int p = 0; p < 2; p++) begin
      c[p+2] = c[p+2] + c[p];     c[p]   = c[p] + c[p+2];
      c[p+6] = c[p+6] + c[p+4];   c[p+4] = c[p+4] + c[p+6];
    end
    for (int p = 0; p < 4; p++) begin
      c[p+4] = c[p+4] + c[p];
      c[p]   = c[p] + c[p+4];
    end
    t = c[1]; c[1] = c[4]; c[4] = c[2]; c[2] = t;
    t = c[3]; c[3] = c[5]; c[5] = c[6]; c[6] = t;
    for (int j = 0; j < 8; j++) pht_round[BLK_W-1-8*j -: 8] = c[j];
  endfunction

  // Inverse shuffle and three inverse PHT layers of a decryption round.
  function automatic logic [BLK_W-1:0] ipht_round(input logic [BLK_W-1:0] x);
    logic [7:0] c [8];
    logic [7:0] t;
    for (int j = 0; j < 8; j++) c[j] = x[BLK_W-1-8*j -: 8];
    t = c[4]; c[4] = c[1]; c[1] = c[2]; c[2] = t;
    t = c[5]; c[5] = c[3]; c[3] = c[6]; c[6] = t;
    for (int p = 0; p < 4; p++) begin
      c[p]   = c[p] - c[p+4];
      c[p+4] = c[p+4] - c[p];
    end
    for (int p = 0; p < 2; p++) begin
      c[p]   = c[p] - c[p+2];     c[p+2] = c[p+2] - c[p];
      c[p+4] = c[p+4] - c[p+6];   c[p+6] = c[p+6] - c[p+4];
    end
    for (int p = 0; p < 8; p += 2) begin
      c[p]   = c[p] - c[p+1];
      c[p+1] = c[p+1] - c[p];
    end
    for (int j = 0; j < 8; j++) ipht_round[BLK_W-1-8*j -: 8] = c[j];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ssk_lane_cell.sv =====
// One byte lane of the cipher state: holds its byte and applies key mixing and S-box.
// Depends on ssk_pkg.
`default_nettype none
module ssk_lane_cell #(
  parameter bit XorLane = 1'b0
) (
  input  wire                 clk_i,
  input  wire ssk_pkg::cell_mode_e mode_i,
  input  wire  [7:0]          load_i,
  input  wire  [7:0]          ka_i,
  input  wire  [7:0]          kb_i,
  input  wire  [7:0]          net_i,
  output logic [7:0]          q_o,
  output logic [7:0]          nl_o,
  output logic [7:0]          nxt_o
);

  logic [7:0] byte_q, byte_d;
  logic [7:0] inv_nl;

  // Forward nonlinear layer on the held byte.
  always_comb begin
    if (XorLane) begin
      nl_o = ssk_pkg::EXP_TAB[byte_q ^ ka_i] + kb_i;
    end else begin
      nl_o = ssk_pkg::LOG_TAB[8'(byte_q + ka_i)] ^ kb_i;
    end
  end

  // Inverse nonlinear layer on the byte coming back from the inverse PHT.
  always_comb begin
    if (XorLane) begin
      inv_nl = ssk_pkg::LOG_TAB[8'(net_i - kb_i)] ^ ka_i;
    end else begin
      inv_nl = ssk_pkg::EXP_TAB[net_i ^ kb_i] - ka_i;
    end
  end

  // Next value of the lane byte.
  always_comb begin
    case (mode_i)
      ssk_pkg::CELL_LOAD:    byte_d = load_i;
      ssk_pkg::CELL_ENC_RND: byte_d = net_i;
      ssk_pkg::CELL_DEC_RND: byte_d = inv_nl;
      ssk_pkg::CELL_ENC_FIN: byte_d = XorLane ? (byte_q ^ ka_i) : 8'(byte_q + ka_i);
      ssk_pkg::CELL_DEC_FIN: byte_d = XorLane ? (byte_q ^ ka_i) : 8'(byte_q - ka_i);
      default:               byte_d = byte_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign q_o   = byte_q;
  assign nxt_o = byte_d;

endmodule
`default_nettype wire

// ===== rtl/core/ssk_key_sched.sv =====
// Key schedule: two rings of nine byte cells produce one round key per cycle.
// Depends on ssk_pkg.
`default_nettype none
module ssk_key_sched #(
  parameter int MaxRounds = ssk_pkg::MAX_ROUNDS,
  parameter int AddrW     = $clog2(2 * MaxRounds + 1)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [ssk_pkg::BLK_W-1:0]    key_first_i,
  input  wire  [ssk_pkg::BLK_W-1:0]    key_second_i,
  input  wire                          long_key_i,
  input  wire  [ssk_pkg::RND_W-1:0]    rounds_i,
  output logic                         we_o,
  output logic [AddrW-1:0]             waddr_o,
  output logic [ssk_pkg::BLK_W-1:0]    wdata_o,
  output logic                         busy_o
);

  logic [ssk_pkg::BLK_W-1:0] second;
  logic [7:0] ka0 [9];
  logic [7:0] kb0 [9];
  logic [7:0] ring_a_q [9];
  logic [7:0] ring_b_q [9];
  logic       busy_q, odd_q;
  logic [ssk_pkg::RND_W-1:0] idx_q, rounds_q;
  logic [AddrW-1:0] wa_q;
  logic [7:0] bias_q;
  logic [ssk_pkg::BLK_W-1:0] word_a, word_b;

  assign second = long_key_i ? key_second_i : key_first_i;

  // Initial register bytes, with the parity byte in place eight.
  always_comb begin
    ka0[8] = '0;
    kb0[8] = '0;
    for (int j = 0; j < 8; j++) begin
      ka0[j] = ssk_pkg::rol8(key_first_i[ssk_pkg::BLK_W-1-8*j -: 8], 5);
      kb0[j] = second[ssk_pkg::BLK_W-1-8*j -: 8];
      ka0[8] = ka0[8] ^ ka0[j];
      kb0[8] = kb0[8] ^ kb0[j];
    end
  end

  // Round key words: ring bytes plus the fixed bias exp(exp(x)).
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      word_a[ssk_pkg::BLK_W-1-8*j -: 8] = ring_a_q[j] +
        ssk_pkg::EXP_TAB[ssk_pkg::EXP_TAB[8'(bias_q + 8'(j))]];
      word_b[ssk_pkg::BLK_W-1-8*j -: 8] = ring_b_q[j] +
        ssk_pkg::EXP_TAB[ssk_pkg::EXP_TAB[8'(bias_q + 8'(j + 9))]];
    end
  end

  // Control of the schedule walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      odd_q    <= 1'b1;
      idx_q    <= '0;
      rounds_q <= '0;
      wa_q     <= '0;
      bias_q   <= '0;
    end else if (start_i) begin
      busy_q   <= (rounds_i != '0);
      odd_q    <= 1'b1;
      idx_q    <= ssk_pkg::RND_W'(1);
      rounds_q <= rounds_i;
      wa_q     <= AddrW'(1);
      bias_q   <= 8'd19;
    end else if (busy_q) begin
      wa_q  <= wa_q + AddrW'(1);
      odd_q <= !odd_q;
      if (!odd_q) begin
        bias_q <= bias_q + 8'd18;
        idx_q  <= idx_q + ssk_pkg::RND_W'(1);
        if (idx_q == rounds_q) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Ring cells take the byte two on, rotated by six (ring A one on at start).
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 9; j++) begin
      if (start_i) begin
        ring_a_q[j] <= ssk_pkg::rol8(ka0[(j + 1) % 9], 6);
        ring_b_q[j] <= ssk_pkg::rol8(kb0[(j + 2) % 9], 6);
      end else if (busy_q && !odd_q) begin
        ring_a_q[j] <= ssk_pkg::rol8(ring_a_q[(j + 2) % 9], 6);
        ring_b_q[j] <= ssk_pkg::rol8(ring_b_q[(j + 2) % 9], 6);
      end
    end
  end

  assign we_o    = start_i | busy_q;
  assign waddr_o = start_i ? '0 : wa_q;
  assign wdata_o = start_i ? second : (odd_q ? word_a : word_b);
  assign busy_o  = busy_q;

endmodule
`default_nettype wire

// ===== rtl/core/safer_sk_block_cipher_core.sv =====
// SAFER SK-64/SK-128 block cipher core: control, round key store and lane cells.
// Depends on ssk_pkg, ssk_lane_cell and ssk_key_sched.
//
// One block is worked on at a time. With the round keys already expanded a block has its
// first round key fetched, then runs R rounds in the row of eight byte cells (R is the
// clamped round count, 8 by default) and a final key mixing, last for encryption and first
// for decryption; the last step waits while an earlier result is stalled in the output
// register. The first block after reset or after any configuration write first runs the key
// schedule, which writes one round key per cycle. A new input beat is taken as soon as the
// core is back in idle, even while the previous result still waits in the output register.
`default_nettype none
module safer_sk_block_cipher_core #(
  parameter int MaxRounds = ssk_pkg::MAX_ROUNDS
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire                             op_i,
  input  wire  [ssk_pkg::BLK_W-1:0]       block_in_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [ssk_pkg::BLK_W-1:0]       block_out_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [ssk_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [ssk_pkg::BLK_W-1:0]       cfg_data_i
);

  localparam int StoreDepth = 2 * MaxRounds + 1;
  localparam int AddrW      = $clog2(StoreDepth);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXPAND = 4'b0010,
    S_START  = 4'b0100,
    S_RUN    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [ssk_pkg::BLK_W-1:0] key_first_q, key_second_q;
  logic                      long_key_q;
  logic [ssk_pkg::RND_W-1:0] round_cnt_q, rounds_clamped, rounds_q;
  logic                      keys_ready_q;
  logic                      op_q;
  logic [ssk_pkg::RND_W-1:0] k_q, k_d;
  logic [AddrW-1:0]          addr_q, addr_d;
  logic                      in_acc, cfg_wr, ks_start, ks_busy, ks_we;
  logic [AddrW-1:0]          ks_waddr;
  logic [ssk_pkg::BLK_W-1:0] ks_wdata;
  logic [ssk_pkg::BLK_W-1:0] rk_mem [StoreDepth];
  logic [ssk_pkg::BLK_W-1:0] rd_a_q, rd_b_q;
  logic [ssk_pkg::BLK_W-1:0] cell_q, cell_nl, cell_nxt, enc_net, dec_net, net;
  ssk_pkg::cell_mode_e       cell_mode;
  logic                      last_step, final_step, out_load;
  logic                      out_valid_q;
  logic [ssk_pkg::BLK_W-1:0] out_q;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  assign rounds_clamped = (round_cnt_q > ssk_pkg::RND_W'(MaxRounds)) ?
                          ssk_pkg::RND_W'(MaxRounds) : round_cnt_q;

  // Configuration registers; any write invalidates the expanded keys.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q  <= '0;
      key_second_q <= '0;
      long_key_q   <= 1'b0;
      round_cnt_q  <= ssk_pkg::ROUND_CNT_RST;
      keys_ready_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index_i)
          ssk_pkg::CFG_KEY_FIRST:  key_first_q  <= cfg_data_i;
          ssk_pkg::CFG_KEY_SECOND: key_second_q <= cfg_data_i;
          ssk_pkg::CFG_LONG_KEY:   long_key_q   <= cfg_data_i[0];
          ssk_pkg::CFG_ROUND_CNT:  round_cnt_q  <= cfg_data_i[ssk_pkg::RND_W-1:0];
          default:                 round_cnt_q  <= round_cnt_q;
        endcase
        keys_ready_q <= 1'b0;
      end else if (ks_start) begin
        keys_ready_q <= 1'b1;
      end
    end
  end

  ssk_key_sched #(
    .MaxRounds (MaxRounds),
    .AddrW     (AddrW)
  ) u_key_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (ks_start),
    .key_first_i  (key_first_q),
    .key_second_i (key_second_q),
    .long_key_i   (long_key_q),
    .rounds_i     (rounds_clamped),
    .we_o         (ks_we),
    .waddr_o      (ks_waddr),
    .wdata_o      (ks_wdata),
    .busy_o       (ks_busy)
  );

  // Round key store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (ks_we) begin
      rk_mem[ks_waddr] <= ks_wdata;
    end
    rd_a_q <= rk_mem[addr_d];
    if (addr_d < AddrW'(StoreDepth - 1)) begin
      rd_b_q <= rk_mem[addr_d + AddrW'(1)];
    end else begin
      rd_b_q <= '0;
    end
  end

  // Sequencer.
  assign last_step  = (k_q == rounds_q);
  assign final_step = op_q ? (k_q == '0) : last_step;

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    k_d       = k_q;
    cell_mode = ssk_pkg::CELL_HOLD;
    ks_start  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cell_mode = ssk_pkg::CELL_LOAD;
          if (keys_ready_q) begin
            state_d = S_START;
          end else begin
            ks_start = 1'b1;
            state_d  = S_EXPAND;
          end
        end
      end
      S_EXPAND: begin
        if (!ks_busy) begin
          state_d = S_START;
        end
      end
      S_START: begin
        addr_d  = op_q ? AddrW'({rounds_q, 1'b0}) : '0;
        k_d     = '0;
        state_d = S_RUN;
      end
      S_RUN: begin
        if (!(last_step && out_valid_q && out_stall_i)) begin
          if (final_step) begin
            cell_mode = op_q ? ssk_pkg::CELL_DEC_FIN : ssk_pkg::CELL_ENC_FIN;
          end else begin
            cell_mode = op_q ? ssk_pkg::CELL_DEC_RND : ssk_pkg::CELL_ENC_RND;
          end
          k_d = k_q + ssk_pkg::RND_W'(1);
          if (last_step) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end else begin
            addr_d = op_q ? (addr_q - AddrW'(2)) : (addr_q + AddrW'(2));
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      addr_q   <= '0;
      k_q      <= '0;
      op_q     <= 1'b0;
      rounds_q <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      k_q     <= k_d;
      if (in_acc) begin
        op_q <= op_i;
      end
      if (ks_start) begin
        rounds_q <= rounds_clamped;
      end
    end
  end

  // Row of byte cells; the PHT network mixes bytes across the lanes each round.
  for (genvar j = 0; j < 8; j++) begin : g_lane
    localparam int Hi = ssk_pkg::BLK_W - 1 - 8 * j;
    ssk_lane_cell #(
      .XorLane ((j == 0) || (j == 3) || (j == 4) || (j == 7))
    ) u_cell (
      .clk_i  (clk_i),
      .mode_i (cell_mode),
      .load_i (block_in_i[Hi -: 8]),
      .ka_i   (rd_a_q[Hi -: 8]),
      .kb_i   (rd_b_q[Hi -: 8]),
      .net_i  (net[Hi -: 8]),
      .q_o    (cell_q[Hi -: 8]),
      .nl_o   (cell_nl[Hi -: 8]),
      .nxt_o  (cell_nxt[Hi -: 8])
    );
  end

  assign enc_net = ssk_pkg::pht_round(cell_nl);
  assign dec_net = ssk_pkg::ipht_round(cell_q);
  assign net     = op_q ? dec_net : enc_net;

  // Output register; frees the cells for the next block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= cell_nxt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign block_out_o = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/ssk_checker.sv =====
// Port-level checks of the SAFER SK core, bound to the top level.
// Depends on safer_sk_block_cipher_core_macros.svh and ssk_pkg.
`default_nettype none
`include "safer_sk_block_cipher_core_macros.svh"
module ssk_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_valid_i,
  input wire                           in_stall_o,
  input wire                           out_valid_o,
  input wire                           out_stall_i,
  input wire [ssk_pkg::BLK_W-1:0]      block_out_o
);

  // A stalled result beat stays and holds its data.
  `SSK_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(block_out_o))

  // An accepted block keeps the input side busy in the next cycle.
  `SSK_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A fresh result only comes out of a block that was being worked on.
  `SSK_ASSERT_IMP(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind safer_sk_block_cipher_core ssk_checker u_ssk_checker (.*);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench of the SAFER SK-64/SK-128 block cipher core.
// Depends on ssk_pkg and safer_sk_block_cipher_core; predicts each output block in place.
module tb_top;
  import ssk_pkg::*;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;
  localparam int STORE_N = 2 * MAX_ROUNDS + 1;

  typedef struct {
    logic        op;
    logic [63:0] blk;
  } cipher_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = 1'b0;
  logic [BLK_W-1:0] block_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [BLK_W-1:0] block_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_KEY_FIRST;
  logic [BLK_W-1:0] cfg_data_i = '0;

  safer_sk_block_cipher_core dut (.*);

  // Predictor state: tables, registers and the expanded round keys.
  logic [7:0]  pow45 [256];
  logic [7:0]  log45 [256];
  logic [63:0] key_a = '0, key_b = '0;
  logic        key_long = 1'b0;
  logic [3:0]  rounds_reg = ROUND_CNT_RST;
  logic [63:0] round_keys [STORE_N];
  logic        keys_valid = 1'b0;
  int          active_rounds = 0;

  cipher_req_t pending_blocks [$];
  logic [63:0] expected_blocks [$];
  int errors = 0, n_enc = 0, n_dec = 0, n_checked = 0, n_phases = 0;
  bit quiet_sender = 0, quiet_receiver = 0, hold_request = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] rotl8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] byte_at(logic [63:0] w, int j);
    return w[63-8*j -: 8];
  endfunction

  function automatic bit xor_first(int j);
    return j == 0 || j == 3 || j == 4 || j == 7;
  endfunction

  // Key schedule of the strengthened variant.
  function automatic void expand_round_keys();
    logic [7:0]  ka [9], kb [9];
    logic [63:0] second, w;
    second = key_long ? key_b : key_a;
    active_rounds = (rounds_reg > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_reg);
    ka[8] = 8'h00;
    kb[8] = 8'h00;
    for (int j = 0; j < 8; j++) begin
      ka[j] = rotl8(byte_at(key_a, j), 5);
      kb[j] = byte_at(second, j);
      ka[8] ^= ka[j];
      kb[8] ^= kb[j];
    end
    round_keys[0] = second;
    for (int i = 1; i <= active_rounds; i++) begin
      for (int j = 0; j < 9; j++) begin
        ka[j] = rotl8(ka[j], 6);
        kb[j] = rotl8(kb[j], 6);
      end
      for (int j = 0; j < 8; j++)
        w[63-8*j -: 8] = ka[(j + 2*i - 1) % 9] + pow45[pow45[(18*i + j + 1) & 8'hFF]];
      round_keys[2*i-1] = w;
      for (int j = 0; j < 8; j++)
        w[63-8*j -: 8] = kb[(j + 2*i) % 9] + pow45[pow45[(18*i + j + 10) & 8'hFF]];
      round_keys[2*i] = w;
    end
    keys_valid = 1'b1;
  endfunction

  function automatic logic [63:0] encrypt_block(logic [63:0] x);
    logic [7:0]  c [8];
    logic [7:0]  t, a, b;
    logic [63:0] k1, k2;
    for (int j = 0; j < 8; j++) c[j] = byte_at(x, j);
    for (int r = 0; r < active_rounds; r++) begin
      k1 = round_keys[2*r];
      k2 = round_keys[2*r+1];
      for (int j = 0; j < 8; j++) begin
        a = byte_at(k1, j);
        b = byte_at(k2, j);
        c[j] = xor_first(j) ? pow45[c[j] ^ a] + b : log45[8'(c[j] + a)] ^ b;
      end
      // Three butterfly layers, each (a,b) -> (2a+b, a+b).
      for (int p = 0; p < 8; p += 2) begin c[p+1] += c[p]; c[p] += c[p+1]; end
      for (int p = 0; p < 2; p++) begin
        c[p+2] += c[p]; c[p] += c[p+2];
        c[p+6] += c[p+4]; c[p+4] += c[p+6];
      end
      for (int p = 0; p < 4; p++) begin c[p+4] += c[p]; c[p] += c[p+4]; end
      t = c[1]; c[1] = c[4]; c[4] = c[2]; c[2] = t;
      t = c[3]; c[3] = c[5]; c[5] = c[6]; c[6] = t;
    end
    k1 = round_keys[2*active_rounds];
    for (int j = 0; j < 8; j++)
      c[j] = xor_first(j) ? c[j] ^ byte_at(k1, j) : c[j] + byte_at(k1, j);
    for (int j = 0; j < 8; j++) x[63-8*j -: 8] = c[j];
    return x;
  endfunction

  function automatic logic [63:0] decrypt_block(logic [63:0] x);
    logic [7:0]  c [8];
    logic [7:0]  t, a, b;
    logic [63:0] k1, k2;
    for (int j = 0; j < 8; j++) c[j] = byte_at(x, j);
    k1 = round_keys[2*active_rounds];
    for (int j = 0; j < 8; j++)
      c[j] = xor_first(j) ? c[j] ^ byte_at(k1, j) : c[j] - byte_at(k1, j);
    for (int r = active_rounds; r > 0; r--) begin
      k1 = round_keys[2*r-2];
      k2 = round_keys[2*r-1];
      t = c[4]; c[4] = c[1]; c[1] = c[2]; c[2] = t;
      t = c[5]; c[5] = c[3]; c[3] = c[6]; c[6] = t;
      for (int p = 0; p < 4; p++) begin c[p] -= c[p+4]; c[p+4] -= c[p]; end
      for (int p = 0; p < 2; p++) begin
        c[p] -= c[p+2]; c[p+2] -= c[p];
        c[p+4] -= c[p+6]; c[p+6] -= c[p+4];
      end
      for (int p = 0; p < 8; p += 2) begin c[p] -= c[p+1]; c[p+1] -= c[p]; end
      for (int j = 0; j < 8; j++) begin
        a = byte_at(k1, j);
        b = byte_at(k2, j);
        c[j] = xor_first(j) ? log45[8'(c[j] - b)] ^ a : pow45[c[j] ^ b] - a;
      end
    end
    for (int j = 0; j < 8; j++) x[63-8*j -: 8] = c[j];
    return x;
  endfunction

  // Sender: offers queued blocks and records the expected output on each accepted beat.
  always @(posedge clk_i) begin
    logic taken;
    taken = in_valid_i && !in_stall_o;
    if (taken) begin
      if (!keys_valid) expand_round_keys();
      if (op_i == OP_DEC) begin
        expected_blocks.push_back(decrypt_block(block_in_i));
        n_dec++;
      end else begin
        expected_blocks.push_back(encrypt_block(block_in_i));
        n_enc++;
      end
      void'(pending_blocks.pop_front());
    end
    if (taken || !in_valid_i) begin
      if (pending_blocks.size() > 0 && (quiet_sender || $urandom_range(99) >= 7)) begin
        in_valid_i <= 1'b1;
        op_i <= pending_blocks[0].op;
        block_in_i <= pending_blocks[0].blk;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with an occasional long hold-off.
  always @(posedge clk_i) begin
    int hold_left;
    if (hold_request) begin
      hold_request = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_receiver && $urandom_range(99) < 7;
    end
  end

  // Output checker.
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected output beat: block_out=%h", block_out_o);
        errors++;
      end else begin
        want = expected_blocks.pop_front();
        n_checked++;
        if (block_out_o !== want) begin
          $error("block_out: expected %h, actual %h", want, block_out_o);
          errors++;
        end
      end
    end
  end

  // One register write; the caller lowers the valid after its last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_KEY_FIRST:  key_a = data;
      CFG_KEY_SECOND: key_b = data;
      CFG_LONG_KEY:   key_long = data[0];
      default:        rounds_reg = data[3:0];
    endcase
    keys_valid = 1'b0;
  endtask

  task automatic configure(logic [63:0] ka, logic [63:0] kb, logic lk, logic [3:0] rc);
    write_reg(CFG_KEY_FIRST, ka);
    write_reg(CFG_KEY_SECOND, kb);
    write_reg(CFG_LONG_KEY, {63'd0, lk});
    write_reg(CFG_ROUND_CNT, {60'd0, rc});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_block(logic op, logic [63:0] blk);
    cipher_req_t r;
    r.op = op;
    r.blk = blk;
    pending_blocks.push_back(r);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      queue_block($urandom_range(1), {$urandom(), $urandom()});
  endtask

  task automatic drain();
    while (pending_blocks.size() > 0 || expected_blocks.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    n_phases++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Stimulus sequence.
  initial begin
    logic [3:0] rc_list [8];
    rc_list = '{4'd0, 4'd1, 4'd13, 4'd14, 4'd15, 4'd8, 4'd5, 4'd12};
    for (int v = 0; v < 256; v++) begin
      pow45[v] = 8'((v == 0) ? 1 : 0);
    end
    begin
      int acc;
      acc = 1;
      for (int v = 0; v < 256; v++) begin
        pow45[v] = acc[7:0];
        log45[acc[7:0]] = 8'(v);
        acc = (acc * 45) % 257;
      end
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset configuration, extreme blocks in both directions.
    foreach (rc_list[i]) if (i < 1) begin end
    queue_block(OP_ENC, 64'h0);
    queue_block(OP_DEC, 64'h0);
    queue_block(OP_ENC, '1);
    queue_block(OP_DEC, '1);
    queue_block(OP_ENC, 64'h8000_0000_0000_0001);
    queue_block(OP_DEC, 64'h0123_4567_89AB_CDEF);
    drain();

    // Directed: extreme keys, short and long, zero and clamped round counts.
    configure('1, 64'h0, 1'b1, 4'd0);
    queue_block(OP_ENC, 64'h0);
    queue_block(OP_DEC, '1);
    drain();
    configure(64'h0, '1, 1'b0, 4'd15);
    queue_block(OP_ENC, '1);
    queue_block(OP_DEC, 64'h0);
    drain();
    configure(64'h0102_0304_0506_0708, 64'h0, 1'b0, 4'd6);
    queue_block(OP_ENC, 64'h0);
    queue_block(OP_DEC, 64'h0);
    drain();

    // Random phases over key sizes and round counts.
    foreach (rc_list[i]) begin
      configure(rand64(), rand64(), 1'(i % 2), rc_list[i]);
      quiet_sender = (i == 2);
      quiet_receiver = (i == 2);
      queue_random(60);
      drain();
    end
    quiet_sender = 0;
    quiet_receiver = 0;

    // Back pressure: receiver holds off while blocks keep coming.
    configure(rand64(), rand64(), 1'b1, 4'd13);
    hold_request = 1;
    queue_random(60);
    drain();

    // A write of a single register between phases also forces a new key expansion.
    for (int i = 0; i < 4; i++) begin
      write_reg(CFG_KEY_FIRST, rand64());
      cfg_valid_i <= 1'b0;
      queue_random(25);
      drain();
      write_reg(CFG_ROUND_CNT, {60'd0, 4'($urandom_range(15))});
      cfg_valid_i <= 1'b0;
      queue_random(25);
      drain();
    end

    $display("Covered %0d encryptions and %0d decryptions over %0d key settings.",
             n_enc, n_dec, n_phases);
    $display("Output blocks compared: %0d.", n_checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timeout with %0d blocks still expected.", expected_blocks.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== safer_sk_block_cipher_core.f =====
+incdir+rtl/core
rtl/core/ssk_pkg.sv
rtl/core/ssk_lane_cell.sv
rtl/core/ssk_key_sched.sv
rtl/core/safer_sk_block_cipher_core.sv
rtl/core/ssk_checker.sv
dv/tb_top.sv
